/* rtl/b64lw_pkg.sv */
// ============================================================================
// b64lw_pkg : shared types and helpers for the line-wrapped Base64 encoder
// Item structs, the group handed from the encode stage to the serializer,
// character codes and the sextet-to-ASCII map.
// ============================================================================
`default_nettype none

package b64lw_pkg;

    localparam int LINE_CHARS_DEF = 76;

    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    // Characters caused by one input item; entry 0 goes out first.
    typedef struct packed {
        logic [5:0][7:0] chars;
        logic [2:0]      count;
        logic            last;
    } t_group;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/b64lw_encode.sv */
// ============================================================================
// b64lw_encode : byte gathering, group encoding and line counting
// Holds pending bytes and the line position; turns one accepted byte into
// the full set of characters it causes, captured in a group register.
// ============================================================================
`default_nettype none

module b64lw_encode #(
    parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  b64lw_pkg::t_in_item   i_in_item,
    output logic                  o_in_stall,
    output logic                  o_grp_valid,
    output b64lw_pkg::t_group     o_grp,
    input  wire                   i_grp_take
);
    import b64lw_pkg::*;

    localparam int GROUPS = LINE_CHARS / 4;
    localparam int GW     = $clog2(GROUPS + 1);
    localparam logic [GW-1:0] GROUPS_C = GW'(GROUPS);

    logic [15:0]   r_pend;
    logic [1:0]    r_pcount;
    logic [GW-1:0] r_gline;
    logic          r_grp_v;
    t_group        r_grp;

    logic [15:0]   n_pend;
    logic [1:0]    n_pcount;
    logic [GW-1:0] n_gline;
    t_group        n_grp;
    logic [GW-1:0] gline_inc;
    logic [23:0]   g;
    logic [7:0]    b;
    logic          accept;

    assign o_in_stall  = r_grp_v && !i_grp_take;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_grp_valid = r_grp_v;
    assign o_grp       = r_grp;

    always_comb begin
        b         = i_in_item.data_byte;
        g         = {r_pend, b};
        gline_inc = r_gline + GW'(1);
        n_pend    = r_pend;
        n_pcount  = r_pcount;
        n_gline   = r_gline;
        n_grp     = '0;
        n_grp.last = i_in_item.end_of_data;
        if (r_pcount[1]) begin
            // third byte completes a group
            n_grp.chars[0] = b64_char(g[23:18]);
            n_grp.chars[1] = b64_char(g[17:12]);
            n_grp.chars[2] = b64_char(g[11:6]);
            n_grp.chars[3] = b64_char(g[5:0]);
            n_grp.count    = 3'd4;
            n_gline        = gline_inc;
            if (gline_inc >= GROUPS_C) begin
                n_grp.chars[4] = CHAR_CR;
                n_grp.chars[5] = CHAR_LF;
                n_grp.count    = 3'd6;
                n_gline        = '0;
            end
            n_pend   = '0;
            n_pcount = '0;
        end else if (i_in_item.end_of_data) begin
            if (r_pcount == 2'd0) begin
                n_grp.chars[0] = b64_char(b[7:2]);
                n_grp.chars[1] = b64_char({b[1:0], 4'b0000});
                n_grp.chars[2] = CHAR_PAD;
                n_grp.chars[3] = CHAR_PAD;
            end else begin
                n_grp.chars[0] = b64_char(r_pend[7:2]);
                n_grp.chars[1] = b64_char({r_pend[1:0], b[7:4]});
                n_grp.chars[2] = b64_char({b[3:0], 2'b00});
                n_grp.chars[3] = CHAR_PAD;
            end
            n_grp.count = 3'd4;
        end else begin
            n_pend   = {r_pend[7:0], b};
            n_pcount = r_pcount + 2'd1;
        end
        // message done: pending bytes and line position back to their reset values
        if (i_in_item.end_of_data) begin
            n_pend   = '0;
            n_pcount = '0;
            n_gline  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_pcount <= '0;
            r_gline  <= '0;
            r_grp_v  <= 1'b0;
        end else begin
            if (accept) begin
                r_pend   <= n_pend;
                r_pcount <= n_pcount;
                r_gline  <= n_gline;
                r_grp_v  <= (n_grp.count != 3'd0);
            end else if (i_grp_take) begin
                r_grp_v  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp <= n_grp;
        end
    end

endmodule

`default_nettype wire

/* rtl/b64lw_serial.sv */
// ============================================================================
// b64lw_serial : character serializer
// Loads one group at a time and shifts its characters out, one per item.
// ============================================================================
`default_nettype none

module b64lw_serial (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_grp_valid,
    input  b64lw_pkg::t_group     i_grp,
    output logic                  o_grp_take,
    output logic                  o_out_valid,
    output b64lw_pkg::t_out_item  o_out_item,
    input  wire                   i_out_stall
);
    import b64lw_pkg::*;

    logic            r_v;
    logic [2:0]      r_left;
    logic [5:0][7:0] r_chars;
    logic            r_last;
    logic            emit;
    logic            final_one;

    assign emit        = r_v && !i_out_stall;
    assign final_one   = (r_left == 3'd1);
    assign o_grp_take  = !r_v || (emit && final_one);
    assign o_out_valid = r_v;

    always_comb begin
        o_out_item.out_char    = r_chars[0];
        o_out_item.run_last    = final_one;
        o_out_item.message_end = final_one && r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            r_left <= '0;
        end else begin
            if (o_grp_take) begin
                r_v    <= i_grp_valid;
                r_left <= i_grp.count;
            end else if (emit) begin
                r_left <= r_left - 3'd1;
            end
        end
    end

    // advance the character line
    always_ff @(posedge i_clk) begin
        if (o_grp_take) begin
            r_chars <= i_grp.chars;
            r_last  <= i_grp.last;
        end else if (emit) begin
            r_chars <= {8'h00, r_chars[5:1]};
        end
    end

endmodule

`default_nettype wire

/* rtl/base64_line_wrapped_encoder_unit.sv */
// A group's characters pass through the group register and then the serializer register on their
// way out, and wait longer while the serializer still drains an earlier group.
// Throughput: one byte per cycle while the group register is free; one character per cycle
// out unless i_out_stall holds it. A group of four or six characters holds the serializer until
// all have gone out, so the output port sets the sustained rate.
// Reset (i_rst_n low at a clock edge) clears pending bytes, line position and all valids.
// ============================================================================
// base64_line_wrapped_encoder_unit : Base64 encoder with 76-character lines
// Byte-per-item input, character-per-item output, CR LF after each full line.
// ============================================================================
`default_nettype none

module base64_line_wrapped_encoder_unit #(
    parameter int LINE_CHARS = b64lw_pkg::LINE_CHARS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // byte input channel
    input  wire                   i_in_valid,
    input  b64lw_pkg::t_in_item   i_in_item,
    output logic                  o_in_stall,
    // character output channel
    output logic                  o_out_valid,
    output b64lw_pkg::t_out_item  o_out_item,
    input  wire                   i_out_stall
);
    import b64lw_pkg::*;

    // Group register between the encoder and the serializer: the encoder may
    // take the next byte while the serializer still drains the previous group.
    logic   grp_valid;
    logic   grp_take;
    t_group grp;

    // Encode stage: pending bytes, line count, full character set per byte.
    b64lw_encode #(
        .LINE_CHARS (LINE_CHARS)
    ) u_encode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_grp_valid (grp_valid),
        .o_grp       (grp),
        .i_grp_take  (grp_take)
    );

    // Serializer: one character per output item, flags on the last one.
    b64lw_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (grp),
        .o_grp_take  (grp_take),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

/* rtl/b64lw_check.sv */
// ============================================================================
// b64lw_check : port-level checks for the line-wrapped Base64 encoder
// Watches the output channel and reset; bound to the top level.
// ============================================================================
`default_nettype none

module b64lw_check (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_out_valid,
    input  b64lw_pkg::t_out_item  i_out_item,
    input  wire                   i_out_stall
);
    import b64lw_pkg::*;

    // message end only closes a run
    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.message_end |-> i_out_item.run_last)
        else $error("message_end without run_last");

    // a run never ends on CR
    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.run_last |-> i_out_item.out_char != CHAR_CR)
        else $error("run ends on CR");

    // stalled output item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_item))
        else $error("stalled output item changed");

    // reset drops the output valid
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind base64_line_wrapped_encoder_unit b64lw_check u_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
